// ===== src/gyi_pkg.sv =====
// Shared types and constants for the gyro yaw integrator.
`default_nettype none

package gyi_pkg;

    // Configuration port widths and register indexes
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_STEP_TIME      = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND       = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIFT_WINDOW   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_OFFSET = 8'd3;

    // Register reset values
    localparam logic [15:0] STEP_TIME_RST    = 16'd5243;
    localparam logic [15:0] DEADBAND_RST     = 16'd512;
    localparam logic [15:0] DRIFT_WINDOW_RST = 16'd3840;

    // Reciprocals, 2^32 / divisor rounded down
    localparam logic [25:0] RECIP_82  = 26'd52377649;
    localparam logic [25:0] RECIP_200 = 26'd21474836;

    // Rounding offsets and divisors
    localparam logic [26:0] RATE_HALF = 27'd41;
    localparam logic [27:0] RATE_DIV  = 28'd82;
    localparam logic [16:0] OFS_HALF  = 17'd100;
    localparam logic [17:0] OFS_DIV   = 18'd200;
    localparam logic [35:0] YAW_HALF_LSB = 36'd2048;

    // Rate saturation magnitudes
    localparam logic [19:0] RATE_POS_MAX = 20'd524287;
    localparam logic [19:0] RATE_NEG_MAG = 20'd524288;

    // Yaw wrap limits, Q.16 degrees
    localparam logic signed [25:0] YAW_HALF_TURN = 26'sd11796480;
    localparam logic signed [25:0] YAW_FULL_TURN = 26'sd23592960;

    // Input request: one gyro sample
    typedef struct packed {
        logic signed [15:0] gyro_raw;
        logic               is_idle;
    } t_in_req;

    // Output request: one result
    typedef struct packed {
        logic signed [24:0] yaw_angle;
        logic signed [19:0] rate_dps;
        logic signed [23:0] offset_now;
    } t_out_req;

endpackage

`default_nettype wire

// ===== src/gyro_yaw_integrator.sv =====
// Yaw integrator with gyro zero-offset tracking, built around one shared multiplier.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+-----------------------------------
//   in       | i_in_valid / o_in_stall    | i_in_data  (gyi_pkg::t_in_req)
//   out      | o_out_valid / i_out_stall  | o_out_data (gyi_pkg::t_out_req)
//   cfg      | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// An accepted sample runs through seven sequencer steps: one to form the
// offset-corrected difference, then multiply/correct pairs for the rate
// (divide by 16.4), the yaw step and the offset update, all on one multiplier.
// A new sample is taken only once the sequencer is back in idle, so one sample is in
// flight at a time; a full output register that is stalled holds the final step.
// Synchronous active-low reset clears yaw, offset and restores register defaults.
`default_nettype none

module gyro_yaw_integrator (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire gyi_pkg::t_in_req                  i_in_data,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output gyi_pkg::t_out_req                      o_out_data,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [gyi_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [gyi_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_PREP     = 8'b0000_0010,
        ST_MUL_RATE = 8'b0000_0100,
        ST_RATE     = 8'b0000_1000,
        ST_MUL_YAW  = 8'b0001_0000,
        ST_YAW      = 8'b0010_0000,
        ST_MUL_OFS  = 8'b0100_0000,
        ST_OFS      = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    // Configuration registers
    logic [15:0]        r_step_time;
    logic [15:0]        r_deadband;
    logic [15:0]        r_drift_window;

    // Block state
    logic signed [24:0] r_yaw;
    logic signed [23:0] r_offset;

    // Per-sample working registers
    gyi_pkg::t_in_req   r_in;
    logic               r_neg;
    logic               r_trk;
    logic [26:0]        r_n;
    logic [16:0]        r_n2;
    logic [19:0]        r_rmag;
    logic signed [19:0] r_rate;
    logic [52:0]        r_prod;

    // Output register
    logic               r_out_valid;
    gyi_pkg::t_out_req  r_out;

    logic               w_accept;
    logic               w_out_free;

    // Difference and deadband
    logic signed [23:0] w_sample;
    logic signed [24:0] w_diff;
    logic [24:0]        w_diff_neg;
    logic [23:0]        w_dmag;
    logic               w_zero;
    logic [26:0]        w_n;
    logic               w_trk;
    logic [16:0]        w_n2;

    // Shared multiplier
    logic [26:0]        w_mul_a;
    logic [25:0]        w_mul_b;
    logic [52:0]        w_prod;

    // Rate correction and saturation
    logic [19:0]        w_q0r;
    logic [27:0]        w_q0r_x82;
    logic [27:0]        w_rem_r;
    logic [19:0]        w_qr;
    logic [19:0]        w_rmag;

    // Yaw update
    logic [23:0]        w_delta;
    logic [35:0]        w_delta_rnd;
    logic signed [25:0] w_yaw_ext;
    logic signed [25:0] w_delta_ext;
    logic signed [25:0] w_yaw_sum;
    logic signed [25:0] w_yaw_wrap;

    // Offset update
    logic [8:0]         w_q0o;
    logic [17:0]        w_q0o_x200;
    logic [17:0]        w_rem_o;
    logic [8:0]         w_qo;
    logic signed [23:0] w_qo_ext;
    logic signed [23:0] w_offset_next;

    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    // Form corrected difference, its magnitude and the tracking decision
    always_comb begin
        w_sample   = {r_in.gyro_raw, 8'h00};
        w_diff     = {w_sample[23], w_sample} - {r_offset[23], r_offset};
        w_diff_neg = -w_diff;
        w_dmag     = w_diff[24] ? w_diff_neg[23:0] : w_diff[23:0];
        w_zero     = (w_dmag < {8'h00, r_deadband});
        w_n        = w_zero ? gyi_pkg::RATE_HALF
                            : ({3'b000, w_dmag} << 2) + {3'b000, w_dmag} + gyi_pkg::RATE_HALF;
        w_trk      = r_in.is_idle && (w_dmag < {8'h00, r_drift_window});
        w_n2       = {1'b0, w_dmag[15:0]} + gyi_pkg::OFS_HALF;
    end

    // Select multiplier operands per step
    always_comb begin
        w_mul_a = r_n;
        w_mul_b = gyi_pkg::RECIP_82;
        unique case (r_state)
            ST_MUL_YAW: begin
                w_mul_a = {7'd0, r_rmag};
                w_mul_b = {10'd0, r_step_time};
            end
            ST_MUL_OFS: begin
                w_mul_a = {10'd0, r_n2};
                w_mul_b = gyi_pkg::RECIP_200;
            end
            default: begin
                w_mul_a = r_n;
                w_mul_b = gyi_pkg::RECIP_82;
            end
        endcase
        w_prod = 53'(w_mul_a) * 53'(w_mul_b);
    end

    // Correct rate quotient by one, then saturate
    always_comb begin
        w_q0r     = r_prod[51:32];
        w_q0r_x82 = ({8'h00, w_q0r} << 6) + ({8'h00, w_q0r} << 4) + ({8'h00, w_q0r} << 1);
        w_rem_r   = {1'b0, r_n} - w_q0r_x82;
        w_qr      = w_q0r + {19'd0, (w_rem_r >= gyi_pkg::RATE_DIV)};
        if (r_neg) begin
            w_rmag = (w_qr > gyi_pkg::RATE_NEG_MAG) ? gyi_pkg::RATE_NEG_MAG : w_qr;
        end else begin
            w_rmag = (w_qr > gyi_pkg::RATE_POS_MAX) ? gyi_pkg::RATE_POS_MAX : w_qr;
        end
    end

    // Round yaw step, accumulate and wrap once
    always_comb begin
        w_delta_rnd = r_prod[35:0] + gyi_pkg::YAW_HALF_LSB;
        w_delta     = w_delta_rnd[35:12];
        w_yaw_ext   = {r_yaw[24], r_yaw};
        w_delta_ext = {2'b00, w_delta};
        w_yaw_sum   = r_neg ? (w_yaw_ext - w_delta_ext) : (w_yaw_ext + w_delta_ext);
        if (w_yaw_sum > gyi_pkg::YAW_HALF_TURN) begin
            w_yaw_wrap = w_yaw_sum - gyi_pkg::YAW_FULL_TURN;
        end else if (w_yaw_sum < -gyi_pkg::YAW_HALF_TURN) begin
            w_yaw_wrap = w_yaw_sum + gyi_pkg::YAW_FULL_TURN;
        end else begin
            w_yaw_wrap = w_yaw_sum;
        end
    end

    // Correct offset step quotient and move the offset toward the sample
    always_comb begin
        w_q0o      = r_prod[40:32];
        w_q0o_x200 = ({9'd0, w_q0o} << 7) + ({9'd0, w_q0o} << 6) + ({9'd0, w_q0o} << 3);
        w_rem_o    = {1'b0, r_n2} - w_q0o_x200;
        w_qo       = w_q0o + {8'd0, (w_rem_o >= gyi_pkg::OFS_DIV)};
        w_qo_ext   = {15'd0, w_qo};
        if (!r_trk) begin
            w_offset_next = r_offset;
        end else if (r_neg) begin
            w_offset_next = r_offset - w_qo_ext;
        end else begin
            w_offset_next = r_offset + w_qo_ext;
        end
    end

    // Advance the sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:     if (w_accept) n_state = ST_PREP;
            ST_PREP:     n_state = ST_MUL_RATE;
            ST_MUL_RATE: n_state = ST_RATE;
            ST_RATE:     n_state = ST_MUL_YAW;
            ST_MUL_YAW:  n_state = ST_YAW;
            ST_YAW:      n_state = ST_MUL_OFS;
            ST_MUL_OFS:  n_state = ST_OFS;
            ST_OFS:      if (w_out_free) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // Control, configuration and block state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_out_valid    <= 1'b0;
            r_step_time    <= gyi_pkg::STEP_TIME_RST;
            r_deadband     <= gyi_pkg::DEADBAND_RST;
            r_drift_window <= gyi_pkg::DRIFT_WINDOW_RST;
            r_yaw          <= '0;
            r_offset       <= '0;
        end else begin
            r_state <= n_state;

            // Drop the result once taken, load a new one when finished
            if (r_state == ST_OFS && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (r_state == ST_YAW) begin
                r_yaw <= w_yaw_wrap[24:0];
            end

            if (r_state == ST_OFS && w_out_free) begin
                r_offset <= w_offset_next;
            end

            // Take configuration writes
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    gyi_pkg::CFG_STEP_TIME:      r_step_time    <= i_cfg_data[15:0];
                    gyi_pkg::CFG_DEADBAND:       r_deadband     <= i_cfg_data[15:0];
                    gyi_pkg::CFG_DRIFT_WINDOW:   r_drift_window <= i_cfg_data[15:0];
                    gyi_pkg::CFG_INITIAL_OFFSET: r_offset       <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Working registers and result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_in_data;
        end
        if (r_state == ST_PREP) begin
            r_neg <= w_diff[24];
            r_trk <= w_trk;
            r_n   <= w_n;
            r_n2  <= w_n2;
        end
        if (r_state == ST_MUL_RATE || r_state == ST_MUL_YAW || r_state == ST_MUL_OFS) begin
            r_prod <= w_prod;
        end
        if (r_state == ST_RATE) begin
            r_rmag <= w_rmag;
            r_rate <= r_neg ? -w_rmag : w_rmag;
        end
        if (r_state == ST_OFS && w_out_free) begin
            r_out.yaw_angle  <= r_yaw;
            r_out.rate_dps   <= r_rate;
            r_out.offset_now <= w_offset_next;
        end
    end

endmodule

`default_nettype wire

// ===== tb/sv/gyi_checker.sv =====
// Watches the gyro yaw integrator channels, predicts each result and compares it.
module gyi_checker
    import gyi_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    input  wire logic                   i_in_stall,
    input  wire t_in_req                i_in_data,
    input  wire logic                   i_out_valid,
    input  wire logic                   i_out_stall,
    input  wire t_out_req               i_out_data,
    input  wire logic                   i_cfg_valid,
    input  wire logic                   i_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    output int                          o_errors,
    output int                          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint HALF_TURN_Q16 = 64'sd11796480;
    localparam longint FULL_TURN_Q16 = 64'sd23592960;
    localparam longint RATE_HI_Q8    = 64'sd524287;
    localparam longint RATE_LO_Q8    = -64'sd524288;

    // Predictor copy of the registers and the running state
    longint step_units;
    longint deadband_q8;
    longint window_q8;
    longint heading_q16;
    longint offset_q8;

    t_out_req results_due[$];
    int       mismatch_count = 0;

    assign o_errors = mismatch_count;

    // Divide rounding to nearest, halves away from zero; den is positive
    function automatic longint div_nearest(input longint num, input longint den);
        if (num >= 0)
            return (num + den / 2) / den;
        return -((-num + den / 2) / den);
    endfunction

    // Advance the predicted heading and offset by one gyro sample
    function automatic t_out_req integrate_sample(input t_in_req s);
        t_out_req res;
        longint   sample_q8;
        longint   diff_q8;
        longint   rate_q8;
        sample_q8 = longint'($signed(s.gyro_raw)) * 256;
        diff_q8   = sample_q8 - offset_q8;
        if (diff_q8 < deadband_q8 && diff_q8 > -deadband_q8)
            diff_q8 = 0;
        // Convert to deg/s (divide by 16.4) and saturate
        rate_q8 = div_nearest(diff_q8 * 10, 164);
        if (rate_q8 > RATE_HI_Q8)
            rate_q8 = RATE_HI_Q8;
        if (rate_q8 < RATE_LO_Q8)
            rate_q8 = RATE_LO_Q8;
        // Integrate and wrap into -180..180 degrees
        heading_q16 += div_nearest(rate_q8 * step_units, 4096);
        while (heading_q16 > HALF_TURN_Q16)
            heading_q16 -= FULL_TURN_Q16;
        while (heading_q16 < -HALF_TURN_Q16)
            heading_q16 += FULL_TURN_Q16;
        // Track zero drift while idle and close to the offset
        if (s.is_idle && sample_q8 > offset_q8 - window_q8
                && sample_q8 < offset_q8 + window_q8)
            offset_q8 += div_nearest(sample_q8 - offset_q8, 200);
        res.yaw_angle  = heading_q16[24:0];
        res.rate_dps   = rate_q8[19:0];
        res.offset_now = offset_q8[23:0];
        return res;
    endfunction

    task automatic report_mismatch(input string field, input logic signed [31:0] want,
                                   input logic signed [31:0] got);
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        mismatch_count++;
    endtask

    // Track resets, register writes, accepted requests and results
    always @(posedge i_clk) begin
        t_out_req want;
        if (!i_rst_n) begin
            step_units  = longint'(STEP_TIME_RST);
            deadband_q8 = longint'(DEADBAND_RST);
            window_q8   = longint'(DRIFT_WINDOW_RST);
            heading_q16 = 0;
            offset_q8   = 0;
            results_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_STEP_TIME:      step_units  = longint'(i_cfg_data[15:0]);
                    CFG_DEADBAND:       deadband_q8 = longint'(i_cfg_data[15:0]);
                    CFG_DRIFT_WINDOW:   window_q8   = longint'(i_cfg_data[15:0]);
                    CFG_INITIAL_OFFSET: offset_q8   = longint'($signed(i_cfg_data));
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (results_due.size() == 0) begin
                    $display("%0t: result with no request pending, got yaw %0d rate %0d "
                             , $time, i_out_data.yaw_angle, i_out_data.rate_dps);
                    mismatch_count++;
                end else begin
                    want = results_due.pop_front();
                    if (i_out_data.yaw_angle !== want.yaw_angle)
                        report_mismatch("yaw_angle", want.yaw_angle, i_out_data.yaw_angle);
                    if (i_out_data.rate_dps !== want.rate_dps)
                        report_mismatch("rate_dps", want.rate_dps, i_out_data.rate_dps);
                    if (i_out_data.offset_now !== want.offset_now)
                        report_mismatch("offset_now", want.offset_now, i_out_data.offset_now);
                end
            end
            if (i_in_valid && !i_in_stall)
                results_due.push_back(integrate_sample(i_in_data));
        end
        o_pending <= results_due.size();
    end

endmodule

// ===== tb/sv/tb.sv =====
// Stimulus and verdict for the gyro yaw integrator testbench.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gyi_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 8'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 8'hFF;
    localparam int RAND_PHASES     = 8;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int HOLD_PHASE      = 3;
    localparam int HOLD_CYCLES     = 400;
    localparam int DRAIN_CYCLES    = 16;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  in_valid;
    logic                  in_stall;
    t_in_req               in_data;
    logic                  out_valid;
    logic                  out_stall;
    t_out_req              out_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    errors;
    int                    pending;

    // Pacing controls shared between the request driver and the drain side
    logic steady   = 1'b0;
    logic hold_req = 1'b0;

    always #10 i_clk = ~i_clk;

    gyro_yaw_integrator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    gyi_checker checker_inst (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    // Mostly short gaps, a few long ones, none while running steady
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (steady || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    // Pick a 16-bit register value, extremes included
    function automatic logic [15:0] pick_reg16(input logic [15:0] typical);
        case ($urandom_range(9))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom);
            default: return 16'($urandom_range(2 * typical));
        endcase
    endfunction

    // Offer one sample and hold it until accepted, then idle a while
    task automatic send_sample(input logic signed [15:0] raw, input logic idle);
        int unsigned gap;
        in_valid         <= 1'b1;
        in_data.gyro_raw <= raw;
        in_data.is_idle  <= idle;
        do
            @(posedge i_clk);
        while (in_stall);
        gap = pick_gap();
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drop the request valid and wait for every result to come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge i_clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Drain side: random stalls plus one long hold-off on request
    initial begin : drain_ctl
        int unsigned stall_left;
        int unsigned hold_left;
        stall_left = 0;
        hold_left  = 0;
        out_stall  = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left != 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end else if (stall_left != 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else begin
                out_stall <= 1'b0;
                if (hold_req) begin
                    hold_req  = 1'b0;
                    hold_left = HOLD_CYCLES;
                end else begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    // Give up on a hung run
    initial begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : stimulus
        int          centre;
        int unsigned spread;
        int          raw;
        logic [15:0] window_val;
        logic [15:0] deadband_val;
        logic [23:0] offset_val;

        i_rst_n   = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Default registers: deadband and window edges, sample extremes
        send_sample(16'sd0, 1'b1);
        send_sample(16'sd1, 1'b0);
        send_sample(16'sd2, 1'b0);
        send_sample(-16'sd1, 1'b1);
        send_sample(-16'sd2, 1'b0);
        send_sample(16'sd14, 1'b1);
        send_sample(16'sd15, 1'b1);
        send_sample(-16'sd15, 1'b1);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(-16'sh8000, 1'b0);
        send_sample(16'sh7FFF, 1'b1);

        // Zero deadband, zero window, longest step, positive rate overflow
        wait_drained();
        write_reg(CFG_STEP_TIME, {8'hA5, 16'hFFFF});
        write_reg(CFG_DEADBAND, {8'h5A, 16'h0000});
        write_reg(CFG_DRIFT_WINDOW, {8'hFF, 16'h0000});
        write_reg(CFG_INITIAL_OFFSET, 24'h800000);
        write_reg(CFG_UNUSED_LO, 24'($urandom));
        write_reg(CFG_UNUSED_HI, 24'($urandom));
        send_sample(16'sh7FFF, 1'b1);
        send_sample(16'sd0, 1'b0);
        send_sample(-16'sh8000, 1'b1);
        send_sample(16'sh7FFF, 1'b0);

        // Zero step, widest deadband and window, negative rate overflow
        wait_drained();
        write_reg(CFG_STEP_TIME, 24'd0);
        write_reg(CFG_DEADBAND, 24'h00FFFF);
        write_reg(CFG_DRIFT_WINDOW, 24'h00FFFF);
        write_reg(CFG_INITIAL_OFFSET, 24'h7FFFFF);
        send_sample(-16'sh8000, 1'b1);
        send_sample(16'sh7FFF, 1'b1);
        send_sample(16'sd0, 1'b1);
        send_sample(-16'sh8000, 1'b0);

        // Random phases, each with its own register settings
        centre = 0;
        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            wait_drained();
            deadband_val = pick_reg16(DEADBAND_RST);
            window_val   = pick_reg16(DRIFT_WINDOW_RST);
            write_reg(CFG_STEP_TIME, {8'($urandom), pick_reg16(STEP_TIME_RST)});
            write_reg(CFG_DEADBAND, {8'($urandom), deadband_val});
            write_reg(CFG_DRIFT_WINDOW, {8'($urandom), window_val});
            if (phase == 0 || $urandom_range(1) == 0) begin
                case ($urandom_range(5))
                    0:       offset_val = 24'h800000;
                    1:       offset_val = 24'h7FFFFF;
                    default: offset_val = 24'(int'($urandom_range(10240)) - 5120);
                endcase
                write_reg(CFG_INITIAL_OFFSET, offset_val);
                centre = int'($signed(offset_val)) >>> 8;
            end
            spread = (window_val >> 8) + (deadband_val >> 8) + 4;
            steady = (phase == HOLD_PHASE);
            if (phase == HOLD_PHASE)
                hold_req = 1'b1;
            repeat (ITEMS_PER_PHASE) begin
                if ($urandom_range(9) < 2) begin
                    raw = int'($signed(16'($urandom)));
                end else begin
                    raw = centre + int'($urandom_range(2 * spread)) - int'(spread);
                    if (raw > 32767)
                        raw = 32767;
                    if (raw < -32768)
                        raw = -32768;
                end
                send_sample(16'(raw), $urandom_range(9) < 6);
            end
            steady = 1'b0;
        end

        // Wait for the last results and give the verdict
        wait_drained();
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
